// File: rtl/blt_pkg.sv
package blt_pkg;

  // configuration port
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL80  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL50  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL20  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_EMPTY    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HYST     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIM     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_DIS_INT  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_CHG_INT  = 3'd7;

  // result queue
  localparam int unsigned FIFO_AW = 2;
  localparam int unsigned FIFO_DEPTH = 1 << FIFO_AW;

  localparam logic [15:0] TICK_MAX = 16'hffff;

  // event codes
  localparam logic [1:0] EVT_UNPLUG = 2'd0;
  localparam logic [1:0] EVT_SLEEP  = 2'd1;
  localparam logic [1:0] EVT_LEVEL  = 2'd2;

  typedef enum logic [2:0] {
    LVL_EMPTY = 3'd0,
    LVL_P20   = 3'd1,
    LVL_P50   = 3'd2,
    LVL_P80   = 3'd3,
    LVL_P99   = 3'd4,
    LVL_FULL  = 3'd5
  } level_t;

  typedef enum logic {
    DIS_INIT = 1'b0,
    DIS_RUN  = 1'b1
  } dis_phase_t;

  typedef enum logic [1:0] {
    CHG_INIT  = 2'd0,
    CHG_LEARN = 2'd1,
    CHG_RUN   = 2'd2,
    CHG_DONE  = 2'd3
  } chg_phase_t;

  typedef struct packed {
    logic        usb_plugged;
    logic        charge_done;
    logic [12:0] battery_mv;
  } in_t;

  typedef struct packed {
    logic [1:0] event_kind;
    logic [2:0] level_code;
    logic       last_of_tick;
  } out_t;

  typedef struct packed {
    logic [12:0] level80_threshold_mv;
    logic [12:0] level50_threshold_mv;
    logic [12:0] level20_threshold_mv;
    logic [12:0] empty_threshold_mv;
    logic [7:0]  hysteresis_mv;
    logic [12:0] full_trim_mv;
    logic [15:0] discharge_interval;
    logic [15:0] charge_interval;
  } cfg_t;

  // results of one transaction pushed into the queue, slot 0 first
  typedef struct packed {
    logic [1:0] n;
    out_t       e0;
    out_t       e1;
  } push_t;

  // band grading with hysteresis; v - h and v + h compares kept unsigned
  function automatic level_t blt_grade(level_t lv, logic [12:0] v, cfg_t c);
    logic [13:0] vw;
    logic [13:0] vh;
    logic [13:0] t80;
    logic [13:0] t50;
    logic [13:0] t20;
    logic [13:0] hw;
    level_t      res;
    vw  = {1'b0, v};
    hw  = {6'b0, c.hysteresis_mv};
    vh  = vw + hw;
    t80 = {1'b0, c.level80_threshold_mv};
    t50 = {1'b0, c.level50_threshold_mv};
    t20 = {1'b0, c.level20_threshold_mv};
    res = lv;
    case (lv)
      LVL_EMPTY: begin
        if (vw > t80) res = LVL_P99;
        else if (vw > t50) res = LVL_P80;
        else if (vw > t20) res = LVL_P50;
        else res = LVL_P20;
      end
      LVL_P99: begin
        if (vh < t80) res = LVL_P80;
      end
      LVL_P80: begin
        if (vw > t80 + hw) res = LVL_P99;
        else if (vh < t50) res = LVL_P50;
      end
      LVL_P50: begin
        if (vw > t50 + hw) res = LVL_P80;
        else if (vh < t20) res = LVL_P20;
      end
      default: begin
        // lowest band, also used for full
        if (vw > t20 + hw) res = LVL_P50;
        else if (v <= c.empty_threshold_mv) res = LVL_EMPTY;
        else res = lv;
      end
    endcase
    return res;
  endfunction

endpackage

// File: rtl/blt_out_fifo.sv
module blt_out_fifo
  import blt_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  push_t push,
  output logic  room_lt2,
  output logic  out_valid,
  input  logic  out_stall,
  output out_t  out_data
);

  out_t                 mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr_r;
  logic [FIFO_AW-1:0]   wr_ptr_nxt;
  logic [FIFO_AW-1:0]   rd_ptr_r;
  logic [FIFO_AW-1:0]   rd_ptr_nxt;
  logic [FIFO_AW:0]     count_r;
  logic [FIFO_AW:0]     count_nxt;
  logic                 pop;

  assign out_valid = (count_r != '0);
  assign out_data  = mem_r[rd_ptr_r];
  assign pop       = out_valid && !out_stall;
  assign room_lt2  = (count_r > (FIFO_AW + 1)'(FIFO_DEPTH - 2));

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + FIFO_AW'(push.n);
    rd_ptr_nxt = rd_ptr_r + FIFO_AW'(pop);
    count_nxt  = count_r + (FIFO_AW + 1)'(push.n) - (FIFO_AW + 1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem_r[wr_ptr_r] <= push.e0;
    end
    if (push.n == 2'd2) begin
      mem_r[wr_ptr_r + FIFO_AW'(1)] <= push.e1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// File: rtl/battery_level_tracker.sv
// results: the results of an accepted tick are registered in the result queue and offered on out_ in order
// throughput: one tick per cycle while in_stall is low; a tick that gives two results needs two output transfers
// the four-entry result queue sets the pace: in_stall is high while fewer than two slots are free
// reset: synchronous on rst_n low; levels, phases, counters and the queue clear,
// configuration registers return to their default values
module battery_level_tracker
  import blt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // tick input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_t                   in_data,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_t                  out_data,
  // configuration write channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t        cfg_r;
  logic [15:0] tick_count_r;
  logic [15:0] tick_count_nxt;
  dis_phase_t  dis_phase_r;
  dis_phase_t  dis_phase_nxt;
  chg_phase_t  chg_phase_r;
  chg_phase_t  chg_phase_nxt;
  level_t      level_now_r;
  level_t      level_now_nxt;
  level_t      level_saved_r;
  level_t      level_saved_nxt;
  logic [12:0] voltage_saved_r;
  logic [12:0] voltage_saved_nxt;
  logic [12:0] offset_mv_r;
  logic [12:0] offset_mv_nxt;

  logic        acc;
  logic        room_lt2;
  push_t       push;

  // per-tick datapath
  logic [12:0] v;
  logic [15:0] tick_inc;
  logic        gt_dis;
  logic        gt_chg;
  logic [12:0] off_dec;
  logic [12:0] corr;
  level_t      g_fresh;
  level_t      g_dis;
  level_t      g_run;

  assign cfg_ready = 1'b1;
  assign in_stall  = room_lt2;
  assign acc       = in_valid && !in_stall;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.level80_threshold_mv <= 13'd3950;
      cfg_r.level50_threshold_mv <= 13'd3750;
      cfg_r.level20_threshold_mv <= 13'd3600;
      cfg_r.empty_threshold_mv   <= 13'd3300;
      cfg_r.hysteresis_mv        <= 8'd25;
      cfg_r.full_trim_mv         <= 13'd4195;
      cfg_r.discharge_interval   <= 16'd1000;
      cfg_r.charge_interval      <= 16'd5000;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_LEVEL80: cfg_r.level80_threshold_mv <= cfg_data[12:0];
        CFG_LEVEL50: cfg_r.level50_threshold_mv <= cfg_data[12:0];
        CFG_LEVEL20: cfg_r.level20_threshold_mv <= cfg_data[12:0];
        CFG_EMPTY:   cfg_r.empty_threshold_mv   <= cfg_data[12:0];
        CFG_HYST:    cfg_r.hysteresis_mv        <= cfg_data[7:0];
        CFG_TRIM:    cfg_r.full_trim_mv         <= cfg_data[12:0];
        CFG_DIS_INT: cfg_r.discharge_interval   <= cfg_data;
        CFG_CHG_INT: cfg_r.charge_interval      <= cfg_data;
        default:     cfg_r.charge_interval      <= cfg_r.charge_interval;
      endcase
    end
  end

  // shared per-tick values: saturating counter, interval checks, corrected voltage, band grades
  always_comb begin
    v        = in_data.battery_mv;
    tick_inc = (tick_count_r == TICK_MAX) ? tick_count_r : tick_count_r + 16'd1;
    gt_dis   = (tick_inc > cfg_r.discharge_interval);
    gt_chg   = (tick_inc > cfg_r.charge_interval);
    // offset trims down by one above the full voltage
    off_dec  = ((v > cfg_r.full_trim_mv) && (offset_mv_r != 13'd0)) ?
               offset_mv_r - 13'd1 : offset_mv_r;
    // corrected voltage clamps at zero
    corr     = (v > off_dec) ? v - off_dec : 13'd0;
    g_fresh  = blt_grade(LVL_EMPTY, v, cfg_r);
    g_dis    = blt_grade(level_now_r, v, cfg_r);
    g_run    = blt_grade(level_now_r, corr, cfg_r);
  end

  // phase next state: entering one mode resets the other one's phase
  always_comb begin
    dis_phase_nxt = dis_phase_r;
    chg_phase_nxt = chg_phase_r;
    if (!in_data.usb_plugged) begin
      chg_phase_nxt = CHG_INIT;
      dis_phase_nxt = DIS_RUN;
    end else begin
      dis_phase_nxt = DIS_INIT;
      case (chg_phase_r)
        CHG_INIT:  chg_phase_nxt = CHG_LEARN;
        CHG_LEARN: if (gt_chg) chg_phase_nxt = CHG_RUN;
        CHG_RUN:   if (in_data.charge_done) chg_phase_nxt = CHG_DONE;
        CHG_DONE:  chg_phase_nxt = CHG_DONE;
        default:   chg_phase_nxt = CHG_INIT;
      endcase
    end
  end

  // level tracking and result generation
  always_comb begin
    tick_count_nxt    = tick_inc;
    level_now_nxt     = level_now_r;
    level_saved_nxt   = level_saved_r;
    voltage_saved_nxt = voltage_saved_r;
    offset_mv_nxt     = offset_mv_r;
    push              = '0;
    if (!in_data.usb_plugged) begin
      if (dis_phase_r == DIS_INIT) begin
        // plug-out: first grade if still empty, then report once
        if (level_now_r == LVL_EMPTY) begin
          voltage_saved_nxt = v;
          level_now_nxt     = g_fresh;
          level_saved_nxt   = g_fresh;
        end
        push.n                = 2'd1;
        push.e0.event_kind    = EVT_UNPLUG;
        push.e0.level_code    = LVL_EMPTY;
        push.e0.last_of_tick  = 1'b1;
        tick_count_nxt        = '0;
      end else if (gt_dis) begin
        // periodic regrade, keep only drops
        tick_count_nxt    = '0;
        voltage_saved_nxt = v;
        level_now_nxt     = g_dis;
        if (g_dis < level_saved_r) begin
          level_saved_nxt = g_dis;
          if (g_dis == LVL_EMPTY) begin
            push.n               = 2'd1;
            push.e0.event_kind   = EVT_SLEEP;
            push.e0.level_code   = LVL_EMPTY;
            push.e0.last_of_tick = 1'b1;
          end
        end
      end
    end else begin
      case (chg_phase_r)
        CHG_INIT: begin
          // plug-in: first grade if still empty, then report the level once
          push.n               = 2'd1;
          push.e0.event_kind   = EVT_LEVEL;
          push.e0.level_code   = level_now_r;
          push.e0.last_of_tick = 1'b1;
          if (level_now_r == LVL_EMPTY) begin
            voltage_saved_nxt  = v;
            level_now_nxt      = g_fresh;
            level_saved_nxt    = g_fresh;
            push.e0.level_code = g_fresh;
          end
          tick_count_nxt = '0;
        end
        CHG_LEARN: begin
          // learn the charger offset over the saved voltage
          if (gt_chg) begin
            tick_count_nxt = '0;
            offset_mv_nxt  = (v > voltage_saved_r) ? v - voltage_saved_r : 13'd0;
          end
        end
        CHG_RUN: begin
          if (gt_chg) begin
            tick_count_nxt    = '0;
            offset_mv_nxt     = off_dec;
            voltage_saved_nxt = corr;
            level_now_nxt     = g_run;
            // report rises only
            if (g_run > level_saved_r) begin
              level_saved_nxt      = g_run;
              push.n               = 2'd1;
              push.e0.event_kind   = EVT_LEVEL;
              push.e0.level_code   = g_run;
              push.e0.last_of_tick = 1'b1;
            end
          end
          // termination forces full, after any rise report of this tick
          if (in_data.charge_done) begin
            level_now_nxt   = LVL_FULL;
            level_saved_nxt = LVL_FULL;
            tick_count_nxt  = '0;
            if (push.n == 2'd1) begin
              push.n               = 2'd2;
              push.e0.last_of_tick = 1'b0;
              push.e1.event_kind   = EVT_LEVEL;
              push.e1.level_code   = LVL_FULL;
              push.e1.last_of_tick = 1'b1;
            end else begin
              push.n               = 2'd1;
              push.e0.event_kind   = EVT_LEVEL;
              push.e0.level_code   = LVL_FULL;
              push.e0.last_of_tick = 1'b1;
            end
          end
        end
        default: begin
          // charge done: only keep sampling
          if (gt_chg) begin
            tick_count_nxt    = '0;
            voltage_saved_nxt = v;
          end
        end
      endcase
    end
    if (!acc) begin
      push.n = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_count_r    <= '0;
      dis_phase_r     <= DIS_INIT;
      chg_phase_r     <= CHG_INIT;
      level_now_r     <= LVL_EMPTY;
      level_saved_r   <= LVL_EMPTY;
      voltage_saved_r <= '0;
      offset_mv_r     <= '0;
    end else if (acc) begin
      tick_count_r    <= tick_count_nxt;
      dis_phase_r     <= dis_phase_nxt;
      chg_phase_r     <= chg_phase_nxt;
      level_now_r     <= level_now_nxt;
      level_saved_r   <= level_saved_nxt;
      voltage_saved_r <= voltage_saved_nxt;
      offset_mv_r     <= offset_mv_nxt;
    end
  end

  // result queue parts the tick side from the result side
  blt_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room_lt2  (room_lt2),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

`ifndef ASSERT_OFF
  a_two_results_only_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    (push.n == 2'd2) |-> (chg_phase_r == CHG_RUN))
    else $error("two results outside charge run phase");

  a_unplug_clears_charge: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && !in_data.usb_plugged) |=> (chg_phase_r == CHG_INIT))
    else $error("charge phase not cleared after unplugged tick");

  a_done_forces_full: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_data.usb_plugged && in_data.charge_done && chg_phase_r == CHG_RUN)
    |=> (level_now_r == LVL_FULL && level_saved_r == LVL_FULL))
    else $error("termination did not force full level");

  a_level_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (level_now_r <= LVL_FULL) && (level_saved_r <= LVL_FULL))
    else $error("level code out of range");
`endif

endmodule
